// File: rtl/abac_pkg.sv
`timescale 1ns / 1ps
// abac_pkg: types, constants and codes shared by the bump arena allocator
// depends on nothing; imported by the top level and abac_div
package abac_pkg;

  localparam int ADDR_W            = 48;
  localparam int SIZE_W            = 32;
  localparam int LG_W              = 4;
  localparam int PAD_W             = 15;
  localparam int CFG_IDX_W         = 1;

  localparam int CP_DEPTH          = 16;
  localparam int RECORD_BYTES      = 16;
  localparam int RECORD_ALIGN_LOG2 = 3;

  localparam int CP_CNT_W = $clog2(CP_DEPTH + 1);
  localparam int CP_IDX_W = (CP_DEPTH > 1) ? $clog2(CP_DEPTH) : 1;
  localparam int DIV_CNT_W = $clog2(SIZE_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE = 1'b0,
    REG_SIZE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_PUSH     = 3'd0,
    MODE_PUSH_ALL = 3'd1,
    MODE_POP      = 3'd2,
    MODE_CP_PUSH  = 3'd3,
    MODE_CP_POP   = 3'd4,
    MODE_CP_DROP  = 3'd5,
    MODE_FLUSH    = 3'd6,
    MODE_NOP      = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_NO_ROOM = 3'd1,
    STAT_POP_BIG = 3'd2,
    STAT_NO_CP   = 3'd3,
    STAT_CP_FULL = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_EXEC,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              go;
    logic [SIZE_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] quot;
    logic [SIZE_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: rtl/arena_bump_allocator_checkpoints_unit.sv
`timescale 1ns / 1ps
// arena_bump_allocator_checkpoints_unit: top level of the bump arena allocator
// depends on abac_pkg, abac_ram (checkpoint stack) and abac_div (push all)
//
// An item is taken when start is high and busy is low. Every item gives one
// result word, shown for one cycle with out_valid; it cannot be held off.
// Most modes step through address and padding, the state update with the
// checkpoint ram access, the free count, then the result word. Push all runs
// the slot count through a bit-serial divider, one quotient bit a cycle.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user
// must do so only while the block is idle, which the block does not enforce.
module arena_bump_allocator_checkpoints_unit
  import abac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_mode,
  input  logic [SIZE_W-1:0]    in_size,
  input  logic [LG_W-1:0]      in_align_log2,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [ADDR_W-1:0]    out_address,
  output logic [SIZE_W-1:0]    out_slot_count,
  output logic [SIZE_W-1:0]    out_bytes_taken,
  output logic [SIZE_W-1:0]    out_bytes_left
);

  state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]    base_r;
  logic [SIZE_W-1:0]    size_r;
  logic [SIZE_W-1:0]    used_r, used_nxt;
  logic [CP_CNT_W-1:0]  cnt_r, cnt_nxt;
  mode_t                mode_r;
  logic [SIZE_W-1:0]    sz_r;
  logic [LG_W-1:0]      lg_r;
  logic [ADDR_W-1:0]    top_r;
  logic [PAD_W-1:0]     pad_r;
  logic [SIZE_W-1:0]    free_r;
  status_t              status_r, status_nxt;
  logic [ADDR_W-1:0]    addr_r, addr_nxt;
  logic [SIZE_W-1:0]    slots_r, slots_nxt;
  logic [SIZE_W-1:0]    taken_r, taken_nxt;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [ADDR_W-1:0]    out_address_r;
  logic [SIZE_W-1:0]    out_slot_count_r;
  logic [SIZE_W-1:0]    out_bytes_taken_r;
  logic [SIZE_W-1:0]    out_bytes_left_r;

  logic                 accept;
  logic [LG_W-1:0]      lg_eff;
  logic [ADDR_W-1:0]    top_calc;
  logic [PAD_W:0]       pad_one;
  logic [PAD_W-1:0]     pad_mask;
  logic [PAD_W-1:0]     pad_calc;
  logic [SIZE_W-1:0]    free_calc;
  logic [SIZE_W-1:0]    eff_sz;
  logic [SIZE_W:0]      need;
  logic                 fit;
  logic                 cp_full;
  logic                 cp_empty;
  logic                 go_div;
  logic [ADDR_W-1:0]    addr_calc;
  logic                 mem_we;
  logic [CP_IDX_W-1:0]  mem_waddr;
  logic [CP_IDX_W-1:0]  mem_raddr;
  logic [SIZE_W-1:0]    mem_rdata;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASE: base_r <= cfg_wdata;
        REG_SIZE: size_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // top of arena, padding and free bytes
  always_comb begin
    lg_eff    = (mode_r == MODE_CP_PUSH) ? LG_W'(RECORD_ALIGN_LOG2) : lg_r;
    top_calc  = base_r + ADDR_W'(used_r);
    pad_one   = (PAD_W + 1)'(1) << lg_eff;
    pad_mask  = PAD_W'(pad_one - (PAD_W + 1)'(1));
    pad_calc  = (~top_calc[PAD_W-1:0] + PAD_W'(1)) & pad_mask;
    free_calc = (used_r > size_r) ? '0 : size_r - used_r;
  end

  // fit check and stack state
  always_comb begin
    eff_sz    = (mode_r == MODE_CP_PUSH) ? SIZE_W'(RECORD_BYTES) : sz_r;
    need      = (SIZE_W + 1)'(pad_r) + {1'b0, eff_sz};
    fit       = (eff_sz != '0) && (need <= {1'b0, free_r});
    addr_calc = top_r + ADDR_W'(pad_r);
    cp_full   = (cnt_r == CP_CNT_W'(CP_DEPTH));
    cp_empty  = (cnt_r == '0);
    go_div    = (mode_r == MODE_PUSH_ALL) && fit;
  end

  assign mem_raddr = CP_IDX_W'(cnt_r - CP_CNT_W'(1));
  assign mem_waddr = CP_IDX_W'(cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = go_div ? ST_DIV : ST_FIN;
      ST_DIV:  if (div_rsp.done) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state update and result
  always_comb begin
    used_nxt         = used_r;
    cnt_nxt          = cnt_r;
    status_nxt       = status_r;
    addr_nxt         = addr_r;
    slots_nxt        = slots_r;
    taken_nxt        = taken_r;
    mem_we           = 1'b0;
    div_req.go       = 1'b0;
    div_req.dividend = free_r - SIZE_W'(pad_r);
    div_req.divisor  = sz_r;
    case (state_r)
      ST_EXEC: begin
        status_nxt = STAT_OK;
        addr_nxt   = '0;
        slots_nxt  = '0;
        taken_nxt  = '0;
        case (mode_r)
          MODE_PUSH: begin
            if (fit) begin
              addr_nxt  = addr_calc;
              taken_nxt = need[SIZE_W-1:0];
              used_nxt  = used_r + need[SIZE_W-1:0];
            end else begin
              status_nxt = STAT_NO_ROOM;
            end
          end
          MODE_PUSH_ALL: begin
            if (fit) begin
              addr_nxt   = addr_calc;
              div_req.go = 1'b1;
            end else begin
              status_nxt = STAT_NO_ROOM;
            end
          end
          MODE_POP: begin
            if (sz_r > used_r) begin
              status_nxt = STAT_POP_BIG;
            end else begin
              used_nxt = used_r - sz_r;
            end
          end
          MODE_CP_PUSH: begin
            if (cp_full) begin
              status_nxt = STAT_CP_FULL;
            end else if (fit) begin
              mem_we    = 1'b1;
              cnt_nxt   = cnt_r + CP_CNT_W'(1);
              addr_nxt  = addr_calc;
              taken_nxt = need[SIZE_W-1:0];
              used_nxt  = used_r + need[SIZE_W-1:0];
            end else begin
              status_nxt = STAT_NO_ROOM;
            end
          end
          MODE_CP_POP: begin
            if (cp_empty) begin
              status_nxt = STAT_NO_CP;
            end else begin
              cnt_nxt = cnt_r - CP_CNT_W'(1);
              if (mem_rdata > used_r) begin
                status_nxt = STAT_POP_BIG;
              end else begin
                used_nxt = mem_rdata;
              end
            end
          end
          MODE_CP_DROP: begin
            if (cp_empty) begin
              status_nxt = STAT_NO_CP;
            end else begin
              cnt_nxt = cnt_r - CP_CNT_W'(1);
            end
          end
          MODE_FLUSH: begin
            used_nxt = '0;
            cnt_nxt  = '0;
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          slots_nxt = div_rsp.quot;
          taken_nxt = free_r - div_rsp.rem;
          used_nxt  = size_r - div_rsp.rem;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == ST_FIN);
    end
    if (accept) begin
      mode_r <= mode_t'(in_mode);
      sz_r   <= in_size;
      lg_r   <= in_align_log2;
    end
    if (state_r == ST_CALC) begin
      top_r  <= top_calc;
      pad_r  <= pad_calc;
      free_r <= free_calc;
    end
    status_r <= status_nxt;
    addr_r   <= addr_nxt;
    slots_r  <= slots_nxt;
    taken_r  <= taken_nxt;
    if (state_r == ST_FIN) begin
      out_status_r      <= status_r;
      out_address_r     <= addr_r;
      out_slot_count_r  <= slots_r;
      out_bytes_taken_r <= taken_r;
      out_bytes_left_r  <= free_calc;
    end
  end

  abac_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (CP_DEPTH)
  ) u_cp_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (used_r),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  abac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_address     = out_address_r;
  assign out_slot_count  = out_slot_count_r;
  assign out_bytes_taken = out_bytes_taken_r;
  assign out_bytes_left  = out_bytes_left_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CP_CNT_W'(CP_DEPTH))
    else $error("checkpoint count above depth");

  a_fin_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> out_valid_r)
    else $error("no result word after finish");

  a_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result word while busy");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider done outside push all");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_CP_FULL)) |-> cp_full)
    else $error("stack full reported below depth");

endmodule

// File: rtl/abac_ram.sv
`timescale 1ns / 1ps
// abac_ram: generic single-write, single-read ram with registered read data
// standalone; holds the checkpoint stack
module abac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/abac_div.sv
`timescale 1ns / 1ps
// abac_div: restoring divider, one quotient bit per cycle
// depends on abac_pkg for widths and the request/response structs
module abac_div
  import abac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]    rem_r, rem_nxt;
  logic [SIZE_W-1:0]    q_r, q_nxt;
  logic [SIZE_W-1:0]    dvs_r, dvs_nxt;
  logic [SIZE_W:0]      shifted;
  logic [SIZE_W:0]      trial;

  always_comb begin
    shifted  = {rem_r, q_r[SIZE_W-1]};
    trial    = shifted - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (req.go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!trial[SIZE_W]) begin
        rem_nxt = trial[SIZE_W-1:0];
        q_nxt   = {q_r[SIZE_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[SIZE_W-1:0];
        q_nxt   = {q_r[SIZE_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(SIZE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

endmodule
